>>> rtl/ppra_pkg.sv
// Package for the preemptive priority resource arbiter.
// Item types, request codes, register indexes and reset values.
// No dependencies.
package ppra_pkg;

  localparam int PRIO_W  = 8;
  localparam int LEVEL_W = PRIO_W + 1;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [1:0] {
    MODE_CHECK   = 2'd0,
    MODE_ACQUIRE = 2'd1,
    MODE_RELEASE = 2'd2,
    MODE_RSVD    = 2'd3
  } mode_t;

  localparam logic [1:0] SRC_VECTOR   = 2'd0;
  localparam logic [1:0] SRC_WAYPOINT = 2'd1;
  localparam logic [1:0] SRC_SAFE     = 2'd2;

  localparam logic [1:0] NO_HOLDER = 2'd0;
  localparam logic signed [LEVEL_W-1:0] LEVEL_NONE = -9'sd1;

  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_VECTOR    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_WAYPOINT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REMOTE_VECTOR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REMOTE_WAYPOINT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SAFE            = 3'd4;

  localparam logic [PRIO_W-1:0] RST_LOCAL_VECTOR    = 8'd1;
  localparam logic [PRIO_W-1:0] RST_LOCAL_WAYPOINT  = 8'd0;
  localparam logic [PRIO_W-1:0] RST_REMOTE_VECTOR   = 8'd3;
  localparam logic [PRIO_W-1:0] RST_REMOTE_WAYPOINT = 8'd2;
  localparam logic [PRIO_W-1:0] RST_SAFE            = 8'd255;

  typedef struct packed {
    logic [1:0] mode;
    logic [1:0] source;
    logic       command_class;
  } req_t;

  typedef struct packed {
    logic       granted;
    logic [1:0] holder_now;
    logic       owns;
    logic       source_revoked;
    logic [2:0] revoked_mask;
  } rsp_t;

  typedef struct packed {
    logic [PRIO_W-1:0] local_vector;
    logic [PRIO_W-1:0] local_waypoint;
    logic [PRIO_W-1:0] remote_vector;
    logic [PRIO_W-1:0] remote_waypoint;
    logic [PRIO_W-1:0] safe;
  } prio_t;

endpackage

>>> rtl/ppra_cfg.sv
// Priority configuration registers of the arbiter.
// Depends on ppra_pkg.
module ppra_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [ppra_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [ppra_pkg::PRIO_W-1:0]    wr_data,
  output ppra_pkg::prio_t               prio
);

  ppra_pkg::prio_t prio_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      prio_reg.local_vector    <= ppra_pkg::RST_LOCAL_VECTOR;
      prio_reg.local_waypoint  <= ppra_pkg::RST_LOCAL_WAYPOINT;
      prio_reg.remote_vector   <= ppra_pkg::RST_REMOTE_VECTOR;
      prio_reg.remote_waypoint <= ppra_pkg::RST_REMOTE_WAYPOINT;
      prio_reg.safe            <= ppra_pkg::RST_SAFE;
    end else if (wr_en) begin
      unique case (wr_index)
        ppra_pkg::REG_LOCAL_VECTOR:    prio_reg.local_vector    <= wr_data;
        ppra_pkg::REG_LOCAL_WAYPOINT:  prio_reg.local_waypoint  <= wr_data;
        ppra_pkg::REG_REMOTE_VECTOR:   prio_reg.remote_vector   <= wr_data;
        ppra_pkg::REG_REMOTE_WAYPOINT: prio_reg.remote_waypoint <= wr_data;
        ppra_pkg::REG_SAFE:            prio_reg.safe            <= wr_data;
        default: ;
      endcase
    end
  end

  assign prio = prio_reg;

endmodule

>>> rtl/ppra_core.sv
// Holder state and grant decision for one request per cycle in which fire is high.
// Depends on ppra_pkg.
module ppra_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  ppra_pkg::req_t  req,
  input  ppra_pkg::prio_t prio,
  output ppra_pkg::rsp_t  rsp
);

  logic [1:0]                             holder;
  logic signed [ppra_pkg::LEVEL_W-1:0]    holder_level;
  logic [2:0]                             revoked_flags;
  logic [1:0]                             holder_next;
  logic signed [ppra_pkg::LEVEL_W-1:0]    holder_level_next;
  logic [2:0]                             revoked_flags_next;

  logic                                   req_ok;
  logic [1:0]                             code;
  logic [2:0]                             bit_mask;
  logic [2:0]                             holder_mask;
  logic [ppra_pkg::PRIO_W-1:0]            prio_sel;
  logic signed [ppra_pkg::LEVEL_W-1:0]    lvl;
  logic                                   free_now;
  logic                                   mine;
  logic                                   wins;
  logic                                   granted;

  always_comb begin
    req_ok   = (req.source <= ppra_pkg::SRC_SAFE) && (req.mode <= ppra_pkg::MODE_RELEASE);
    code     = req.source + 2'd1;
    bit_mask = 3'b001 << req.source;
    holder_mask = 3'b001 << (holder - 2'd1);
    if (req.source == ppra_pkg::SRC_SAFE) begin
      prio_sel = prio.safe;
    end else if (req.source == ppra_pkg::SRC_VECTOR) begin
      prio_sel = req.command_class ? prio.remote_vector : prio.local_vector;
    end else begin
      prio_sel = req.command_class ? prio.remote_waypoint : prio.local_waypoint;
    end
    lvl      = $signed({1'b0, prio_sel});
    free_now = (holder == ppra_pkg::NO_HOLDER);
    mine     = (holder == code);
    wins     = free_now || mine || (lvl > holder_level);

    holder_next        = holder;
    holder_level_next  = holder_level;
    revoked_flags_next = revoked_flags;
    granted            = 1'b0;
    if (req_ok) begin
      case (req.mode)
        ppra_pkg::MODE_CHECK: begin
          granted = wins;
        end
        ppra_pkg::MODE_ACQUIRE: begin
          if (wins) begin
            holder_next        = code;
            holder_level_next  = lvl;
            revoked_flags_next = (revoked_flags | (free_now || mine ? 3'b000 : holder_mask))
                                 & ~bit_mask;
            granted            = 1'b1;
          end
        end
        ppra_pkg::MODE_RELEASE: begin
          if (mine) begin
            holder_next       = ppra_pkg::NO_HOLDER;
            holder_level_next = ppra_pkg::LEVEL_NONE;
          end
          revoked_flags_next = revoked_flags & ~bit_mask;
          granted            = 1'b1;
        end
        default: ;
      endcase
    end

    rsp.granted        = granted;
    rsp.holder_now     = holder_next;
    rsp.owns           = req_ok && (holder_next == code);
    rsp.source_revoked = req_ok && |(revoked_flags_next & bit_mask);
    rsp.revoked_mask   = revoked_flags_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      holder        <= ppra_pkg::NO_HOLDER;
      holder_level  <= ppra_pkg::LEVEL_NONE;
      revoked_flags <= 3'b000;
    end else if (fire) begin
      holder        <= holder_next;
      holder_level  <= holder_level_next;
      revoked_flags <= revoked_flags_next;
    end
  end

  // no holder exactly when the stored level is the empty marker
  a_level_none: assert property (@(posedge clk) disable iff (rst)
    (holder == ppra_pkg::NO_HOLDER) == (holder_level == ppra_pkg::LEVEL_NONE))
    else $error("holder and holder_level disagree");

  // the current holder is never marked revoked
  a_holder_clean: assert property (@(posedge clk) disable iff (rst)
    (holder != ppra_pkg::NO_HOLDER) |-> !(|(revoked_flags & holder_mask)))
    else $error("holder carries a revoked mark");

  // a granted acquire hands the resource to the requester
  a_acquire_takes: assert property (@(posedge clk) disable iff (rst)
    (fire && req_ok && req.mode == ppra_pkg::MODE_ACQUIRE && wins) |=>
      (holder == $past(code)))
    else $error("granted acquire did not take the resource");

endmodule

>>> rtl/preemptive_priority_resource_arbiter.sv
// Preemptive priority resource arbiter, top level.
// Result path: the accepted item is held in the input reg, then its result in the result reg.
// Throughput: one item per cycle while out_stall does not hold a result; the decision is combinational in ppra_core.
// Reset (rst, synchronous): no holder, no revoked marks, priorities to defaults.
// Depends on ppra_pkg, ppra_cfg, ppra_core.
module preemptive_priority_resource_arbiter (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  ppra_pkg::req_t                 in_item,
  output logic                           out_valid,
  input  logic                           out_stall,
  output ppra_pkg::rsp_t                 out_item,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ppra_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ppra_pkg::PRIO_W-1:0]    cfg_data
);

  ppra_pkg::prio_t prio;
  ppra_pkg::req_t  s1_req;
  ppra_pkg::rsp_t  core_rsp;
  ppra_pkg::rsp_t  out_reg;
  logic            s1_valid;
  logic            s1_valid_next;
  logic            out_valid_reg;
  logic            out_valid_next;
  logic            out_free;
  logic            s1_adv;
  logic            accept;

  assign cfg_ready = 1'b1;

  ppra_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .prio     (prio)
  );

  ppra_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (s1_adv),
    .req  (s1_req),
    .prio (prio),
    .rsp  (core_rsp)
  );

  always_comb begin
    out_free       = !out_valid_reg || !out_stall;
    s1_adv         = s1_valid && out_free;
    in_stall       = s1_valid && !out_free;
    accept         = in_valid && !in_stall;
    s1_valid_next  = accept || (s1_valid && !s1_adv);
    out_valid_next = s1_adv || (out_valid_reg && out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      out_valid_reg <= 1'b0;
    end else begin
      s1_valid      <= s1_valid_next;
      out_valid_reg <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req <= in_item;
    end
    if (s1_adv) begin
      out_reg <= core_rsp;
    end
  end

  assign out_valid = out_valid_reg;
  assign out_item  = out_reg;

  // input side stalls only when a held item cannot move on
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid_reg && out_stall))
    else $error("input stalled without a blocked result");

  // a held result stays while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(out_reg)))
    else $error("stalled result changed");

  // every advanced item shows up as a result
  a_advance: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> out_valid_reg)
    else $error("advanced item produced no result");

endmodule
